### src/pdg_pkg.sv
// ----------------------------------------------------------------------------
// pdg_pkg
// Shared codes and status types of the Poisson-disc grid check block.
// ----------------------------------------------------------------------------
package pdg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int INV_W      = 16;
  localparam int DIST_W     = 32;
  localparam int DIM_REG_W  = 5;
  localparam int COUNT_W    = 16;
  localparam int CMD_W      = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 3'd7;

  // Commands; the unused code behaves as a plain check
  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SEED   = 2'd2
  } pdg_cmd_t;

  // Axis difference beyond which a stored point is never too close
  localparam int FAR_LIMIT = 65536;
  localparam int SQ_IN_W   = 17;
  localparam int SQ_W      = 2 * SQ_IN_W;
  localparam int SUM_W     = SQ_W + 2;

  // Neighbor read tag that travels beside the memory read
  typedef struct packed {
    logic vld;
    logic last;
  } pdg_tap_t;

  // Distance checker status toward the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } pdg_dist_t;

endpackage

### src/poisson_disc_grid_check_top.sv
// ----------------------------------------------------------------------------
// poisson_disc_grid_check_top
// 3D Poisson-disc background grid: neighbor check and insert of candidates.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid store once, clearing all GRID_DIM_MAX**3
// cells (4096 by default), and takes no candidate beat until the sweep is done;
// configuration writes are taken at any time. Each candidate then passes from
// input beat to result through cell arithmetic, 27 reads of the neighbor cells
// through the single read port of the grid memory, the read and distance
// pipeline, and a finish step that writes an inserted point back and also
// loads the output register. One candidate is in work at a time; a result
// waiting in the output register does not block the next input beat.
module poisson_disc_grid_check_top
  import pdg_pkg::*;
#(
  parameter int GRID_DIM_MAX = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // pos_x, pos_y, pos_z, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic [CMD_W-1:0]        s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // is_clear, inserted, home_cell, point_count, zero fill
  output logic [((2+$clog2(GRID_DIM_MAX**3)+COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int DW     = $clog2(GRID_DIM_MAX + 1);
  localparam int CW     = $clog2(GRID_DIM_MAX);
  localparam int CELLS  = GRID_DIM_MAX ** 3;
  localparam int AW     = $clog2(CELLS);
  localparam int GW     = COORD_BITS + 2;
  localparam int MEM_W  = 3 * COORD_BITS + 1;
  localparam int OUT_W  = ((2 + AW + COUNT_W + 7) / 8) * 8;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [COORD_BITS-1:0] origin_x, origin_y, origin_z;
  logic [INV_W-1:0]      inv_cell_size;
  logic [DIST_W-1:0]     min_dist_sq;
  logic [DIM_REG_W-1:0]  grid_width, grid_height, grid_depth;
  logic [DW-1:0]         dim_w, dim_h, dim_d;

  logic                  in_beat, calc_done, finish_fire, do_insert, is_clear;
  logic [CMD_W-1:0]      cmd_q;
  logic [AW-1:0]         clr_cnt;
  logic [1:0]            dxc, dyc, dzc;
  logic [COORD_BITS-1:0] cand_x, cand_y, cand_z;
  logic signed [GW-1:0]  gx, gy, gz, nx, ny, nz;
  logic [2*DW-1:0]       wh;
  logic [AW-1:0]         home, nb_addr;
  logic                  nb_in;
  logic [CW+DW-1:0]      ny_off;
  logic [CW+2*DW-1:0]    nz_off;
  pdg_tap_t              tap;
  pdg_dist_t             dist_st;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MEM_W-1:0]      mem_wdata, mem_rdata;
  logic [COUNT_W-1:0]    point_count, point_count_next;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_data;

  function automatic logic [DW-1:0] eff_dim(input logic [DIM_REG_W-1:0] r);
    if (r == '0) begin
      return DW'(1);
    end else if (32'(r) > GRID_DIM_MAX) begin
      return DW'(GRID_DIM_MAX);
    end
    return DW'(r);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      inv_cell_size <= INV_W'(256);
      min_dist_sq   <= DIST_W'(65536);
      grid_width    <= DIM_REG_W'(16);
      grid_height   <= DIM_REG_W'(16);
      grid_depth    <= DIM_REG_W'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    origin_x      <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:    origin_y      <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Z:    origin_z      <= cfg_data[COORD_BITS-1:0];
        REG_INV_CELL:    inv_cell_size <= cfg_data[INV_W-1:0];
        REG_MIN_DIST_SQ: min_dist_sq   <= cfg_data[DIST_W-1:0];
        REG_GRID_WIDTH:  grid_width    <= cfg_data[DIM_REG_W-1:0];
        REG_GRID_HEIGHT: grid_height   <= cfg_data[DIM_REG_W-1:0];
        REG_GRID_DEPTH:  grid_depth    <= cfg_data[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign dim_w = eff_dim(grid_width);
  assign dim_h = eff_dim(grid_height);
  assign dim_d = eff_dim(grid_depth);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  pdg_cell_calc #(
    .GRID_DIM_MAX (GRID_DIM_MAX),
    .COORD_BITS   (COORD_BITS)
  ) u_calc (
    .clk           (clk),
    .rst           (rst),
    .start         (in_beat),
    .pos_x         (s_axis_tdata[COORD_BITS-1:0]),
    .pos_y         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pos_z         (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .origin_z      (origin_z),
    .inv_cell_size (inv_cell_size),
    .dim_w         (dim_w),
    .dim_h         (dim_h),
    .dim_d         (dim_d),
    .cand_x        (cand_x),
    .cand_y        (cand_y),
    .cand_z        (cand_z),
    .gx            (gx),
    .gy            (gy),
    .gz            (gz),
    .wh            (wh),
    .home          (home),
    .done          (calc_done)
  );

  // Neighbor address: offsets -1..+1 coded as 0..2
  always_comb begin
    nx = gx + $signed(GW'(dxc)) - GW'(1);
    ny = gy + $signed(GW'(dyc)) - GW'(1);
    nz = gz + $signed(GW'(dzc)) - GW'(1);
    nb_in = !nx[GW-1] && (nx < $signed(GW'(dim_w)))
         && !ny[GW-1] && (ny < $signed(GW'(dim_h)))
         && !nz[GW-1] && (nz < $signed(GW'(dim_d)));
    ny_off  = ny[CW-1:0] * dim_w;
    nz_off  = nz[CW-1:0] * wh;
    nb_addr = AW'(nx[CW-1:0]) + AW'(ny_off) + AW'(nz_off);
    tap.vld  = (state == ST_SCAN) && nb_in;
    tap.last = (state == ST_SCAN) && (dxc == 2'd2) && (dyc == 2'd2) && (dzc == 2'd2);
  end

  always_comb begin
    is_clear    = !dist_st.hit;
    do_insert   = (cmd_q == CMD_SEED) || ((cmd_q == CMD_INSERT) && is_clear);
    finish_fire = (state == ST_FINISH) && (!out_valid || m_axis_tready);
    point_count_next = point_count;
    if (do_insert && (point_count != '1)) begin
      point_count_next = point_count + COUNT_W'(1);
    end
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = finish_fire && do_insert;
      mem_waddr = home;
      mem_wdata = {1'b1, cand_z, cand_y, cand_x};
    end
  end

  pdg_grid_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (AW),
    .DATA_W (MEM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state == ST_SCAN),
    .raddr (nb_addr),
    .rdata (mem_rdata)
  );

  pdg_dist_check #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .start       (in_beat),
    .tap_in      (tap),
    .rdata       (mem_rdata),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .cand_z      (cand_z),
    .min_dist_sq (min_dist_sq),
    .status      (dist_st)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_cnt == LAST_CELL) state_next = ST_IDLE;
      ST_IDLE:   if (in_beat) state_next = ST_CALC;
      ST_CALC:   if (calc_done) state_next = ST_SCAN;
      ST_SCAN:   if (tap.last) state_next = ST_DRAIN;
      ST_DRAIN:  if (dist_st.done) state_next = ST_FINISH;
      ST_FINISH: if (finish_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      dxc         <= '0;
      dyc         <= '0;
      dzc         <= '0;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_SCAN) begin
        if (dzc == 2'd2) begin
          dzc <= '0;
          if (dyc == 2'd2) begin
            dyc <= '0;
            dxc <= (dxc == 2'd2) ? 2'd0 : dxc + 2'd1;
          end else begin
            dyc <= dyc + 2'd1;
          end
        end else begin
          dzc <= dzc + 2'd1;
        end
      end
      if (finish_fire) begin
        point_count <= point_count_next;
        out_valid   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q <= s_axis_tuser;
    end
    if (finish_fire) begin
      out_data <= OUT_W'({point_count_next, home, do_insert, is_clear});
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

### src/pdg_grid_mem.sv
// ----------------------------------------------------------------------------
// pdg_grid_mem
// Grid cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pdg_grid_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 49
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pdg_cell_calc.sv
// ----------------------------------------------------------------------------
// pdg_cell_calc
// Candidate cell coordinates: offset, scale by inverse cell size, truncate,
// then clamp into the grid for the home cell index.
// ----------------------------------------------------------------------------
module pdg_cell_calc
  import pdg_pkg::*;
#(
  parameter int GRID_DIM_MAX = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [COORD_BITS-1:0]                  pos_x,
  input  logic [COORD_BITS-1:0]                  pos_y,
  input  logic [COORD_BITS-1:0]                  pos_z,
  input  logic [COORD_BITS-1:0]                  origin_x,
  input  logic [COORD_BITS-1:0]                  origin_y,
  input  logic [COORD_BITS-1:0]                  origin_z,
  input  logic [INV_W-1:0]                       inv_cell_size,
  input  logic [$clog2(GRID_DIM_MAX+1)-1:0]      dim_w,
  input  logic [$clog2(GRID_DIM_MAX+1)-1:0]      dim_h,
  input  logic [$clog2(GRID_DIM_MAX+1)-1:0]      dim_d,
  output logic [COORD_BITS-1:0]                  cand_x,
  output logic [COORD_BITS-1:0]                  cand_y,
  output logic [COORD_BITS-1:0]                  cand_z,
  output logic signed [COORD_BITS+1:0]           gx,
  output logic signed [COORD_BITS+1:0]           gy,
  output logic signed [COORD_BITS+1:0]           gz,
  output logic [2*$clog2(GRID_DIM_MAX+1)-1:0]    wh,
  output logic [$clog2(GRID_DIM_MAX**3)-1:0]     home,
  output logic                                   done
);

  localparam int DW = $clog2(GRID_DIM_MAX + 1);
  localparam int CW = $clog2(GRID_DIM_MAX);
  localparam int AW = $clog2(GRID_DIM_MAX ** 3);
  localparam int OW = COORD_BITS + 1;
  localparam int PW = COORD_BITS + 18;
  localparam int GW = COORD_BITS + 2;

  logic signed [OW-1:0] off_x, off_y, off_z;
  logic signed [PW-1:0] prod_x, prod_y, prod_z;
  logic        [4:0]    sr;
  logic        [CW-1:0] cx, cy, cz;
  logic [CW+DW-1:0]     hy;
  logic [CW+2*DW-1:0]   hz;

  // Truncate toward zero after dropping the 16 fraction bits
  function automatic logic signed [GW-1:0] trunc_cell(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [GW-1:0] sh;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    sh  = mag[PW-1:16];
    return p[PW-1] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic [CW-1:0] clamp_cell(input logic signed [GW-1:0] g,
                                               input logic [DW-1:0] dim);
    logic [DW-1:0] dm1;
    dm1 = dim - DW'(1);
    if (g[GW-1]) begin
      return '0;
    end else if (g >= $signed(GW'(dim))) begin
      return dm1[CW-1:0];
    end
    return g[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sr <= '0;
    end else begin
      sr <= {sr[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cand_x <= pos_x;
      cand_y <= pos_y;
      cand_z <= pos_z;
    end
    off_x  <= $signed({cand_x[COORD_BITS-1], cand_x}) - $signed({origin_x[COORD_BITS-1], origin_x});
    off_y  <= $signed({cand_y[COORD_BITS-1], cand_y}) - $signed({origin_y[COORD_BITS-1], origin_y});
    off_z  <= $signed({cand_z[COORD_BITS-1], cand_z}) - $signed({origin_z[COORD_BITS-1], origin_z});
    prod_x <= off_x * $signed({1'b0, inv_cell_size});
    prod_y <= off_y * $signed({1'b0, inv_cell_size});
    prod_z <= off_z * $signed({1'b0, inv_cell_size});
    gx     <= trunc_cell(prod_x);
    gy     <= trunc_cell(prod_y);
    gz     <= trunc_cell(prod_z);
    wh     <= dim_w * dim_h;
    home   <= AW'(cx) + AW'(hy) + AW'(hz);
  end

  always_comb begin
    cx = clamp_cell(gx, dim_w);
    cy = clamp_cell(gy, dim_h);
    cz = clamp_cell(gz, dim_d);
    hy = cy * dim_w;
    hz = cz * wh;
  end

  assign done = sr[4];

endmodule

### src/pdg_dist_check.sv
// ----------------------------------------------------------------------------
// pdg_dist_check
// Distance pipeline: stored neighbor point against the candidate, squared
// distance below the threshold sets the hit flag for the current item.
// ----------------------------------------------------------------------------
module pdg_dist_check
  import pdg_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  pdg_tap_t                  tap_in,
  input  logic [3*COORD_BITS:0]     rdata,
  input  logic [COORD_BITS-1:0]     cand_x,
  input  logic [COORD_BITS-1:0]     cand_y,
  input  logic [COORD_BITS-1:0]     cand_z,
  input  logic [DIST_W-1:0]         min_dist_sq,
  output pdg_dist_t                 status
);

  localparam int DFW = COORD_BITS + 1;
  localparam int EW  = (DFW > 18) ? DFW : 18;
  localparam logic [EW-1:0] LIM = EW'(FAR_LIMIT);

  pdg_tap_t           tap_q, tap_a, tap_b;
  logic               last_c, hit;
  logic [DFW-1:0]     ax, ay, az;
  logic               far, occ;
  logic [SQ_IN_W-1:0] a_x, a_y, a_z;
  logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]   dist_sum;

  function automatic logic [DFW-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b);
    logic signed [DFW-1:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return d[DFW-1] ? DFW'(-d) : DFW'(d);
  endfunction

  always_comb begin
    occ = rdata[3*COORD_BITS];
    ax  = abs_diff(cand_x, rdata[COORD_BITS-1:0]);
    ay  = abs_diff(cand_y, rdata[2*COORD_BITS-1:COORD_BITS]);
    az  = abs_diff(cand_z, rdata[3*COORD_BITS-1:2*COORD_BITS]);
    far = (EW'(ax) > LIM) || (EW'(ay) > LIM) || (EW'(az) > LIM);
    dist_sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_q  <= '0;
      tap_a  <= '0;
      tap_b  <= '0;
      last_c <= 1'b0;
      hit    <= 1'b0;
    end else begin
      tap_q      <= tap_in;
      tap_a.vld  <= tap_q.vld && occ && !far;
      tap_a.last <= tap_q.last;
      tap_b      <= tap_a;
      last_c     <= tap_b.last;
      if (start) begin
        hit <= 1'b0;
      end else if (tap_b.vld && (dist_sum < SUM_W'(min_dist_sq))) begin
        hit <= 1'b1;
      end
    end
  end

  // Magnitudes are at most 65536 (FAR_LIMIT) here whenever the tap is kept
  always_ff @(posedge clk) begin
    a_x  <= EW'(ax) > LIM ? '0 : SQ_IN_W'(ax);
    a_y  <= EW'(ay) > LIM ? '0 : SQ_IN_W'(ay);
    a_z  <= EW'(az) > LIM ? '0 : SQ_IN_W'(az);
    sq_x <= a_x * a_x;
    sq_y <= a_y * a_y;
    sq_z <= a_z * a_z;
  end

  assign status.done = last_c;
  assign status.hit  = hit;

endmodule
